### hw/rtl/clsr_pkg.sv
package clsr_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int WARMUP      = 8;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int QW          = SLOT_W + 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + WARMUP);

    localparam int VAL_W  = 31;
    localparam int MUL_W  = 16;
    localparam int PROD_W = VAL_W + MUL_W;
    localparam int FOLD_W = 8;
    localparam int SUM_W  = VAL_W + 1;

    localparam longint unsigned MOD_ONE_L = 64'd2147483563;
    localparam longint unsigned MOD_TWO_L = 64'd2147483399;
    localparam longint unsigned SLOT_DIV_L = 64'd1 + (MOD_ONE_L - 64'd1) / TABLE_DEPTH;
    localparam longint unsigned RECIP_L = (64'd1 << 32) / SLOT_DIV_L;
    localparam int RECIP_W = $clog2(RECIP_L + 64'd1);
    localparam int EST_W   = VAL_W + RECIP_W;

    localparam logic [VAL_W-1:0]   MOD_ONE   = VAL_W'(MOD_ONE_L);
    localparam logic [VAL_W-1:0]   MOD_TWO   = VAL_W'(MOD_TWO_L);
    localparam logic [VAL_W-1:0]   TOP_VALUE = VAL_W'(MOD_ONE_L - 64'd1);
    localparam logic [MUL_W-1:0]   MUL_ONE   = 16'd40014;
    localparam logic [MUL_W-1:0]   MUL_TWO   = 16'd40692;
    localparam logic [FOLD_W-1:0]  FOLD_ONE  = FOLD_W'((64'd1 << VAL_W) - MOD_ONE_L);
    localparam logic [FOLD_W-1:0]  FOLD_TWO  = FOLD_W'((64'd1 << VAL_W) - MOD_TWO_L);
    localparam logic [VAL_W-1:0]   SLOT_DIV  = VAL_W'(SLOT_DIV_L);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
    localparam logic [VAL_W-1:0]   G2_RESET  = 31'd123456789;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } table_wr_t;

endpackage

### hw/rtl/clsr_lcg.sv
module clsr_lcg
    import clsr_pkg::*;
(
    input  logic             aclk,
    input  logic [VAL_W-1:0] g1,
    input  logic [VAL_W-1:0] g2,
    output logic [VAL_W-1:0] g1_step,
    output logic [VAL_W-1:0] g2_step
);

    logic [PROD_W-1:0] p1_reg;
    logic [PROD_W-1:0] p2_reg;
    logic [VAL_W-1:0]  g1_step_reg;
    logic [VAL_W-1:0]  g2_step_reg;
    logic [SUM_W-1:0]  s1;
    logic [SUM_W-1:0]  s2;

    // 2^31 folds to (2^31 - m); the sum stays below 2m, one subtract finishes
    always_comb begin
        s1 = SUM_W'(p1_reg[PROD_W-1:VAL_W]) * SUM_W'(FOLD_ONE) + SUM_W'(p1_reg[VAL_W-1:0]);
        s2 = SUM_W'(p2_reg[PROD_W-1:VAL_W]) * SUM_W'(FOLD_TWO) + SUM_W'(p2_reg[VAL_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        p1_reg <= PROD_W'(g1) * PROD_W'(MUL_ONE);
        p2_reg <= PROD_W'(g2) * PROD_W'(MUL_TWO);
        g1_step_reg <= (s1 >= SUM_W'(MOD_ONE)) ? VAL_W'(s1 - SUM_W'(MOD_ONE)) : VAL_W'(s1);
        g2_step_reg <= (s2 >= SUM_W'(MOD_TWO)) ? VAL_W'(s2 - SUM_W'(MOD_TWO)) : VAL_W'(s2);
    end

    assign g1_step = g1_step_reg;
    assign g2_step = g2_step_reg;

endmodule

### hw/rtl/clsr_slot.sv
module clsr_slot
    import clsr_pkg::*;
(
    input  logic              aclk,
    input  logic [VAL_W-1:0]  last,
    output logic [SLOT_W-1:0] slot
);

    logic [EST_W-1:0] est;
    logic [VAL_W-1:0] x1_reg;
    logic [QW-1:0]    q1_reg;
    logic [VAL_W-1:0] x2_reg;
    logic [QW-1:0]    q2_reg;
    logic [VAL_W-1:0] p2_reg;
    logic [VAL_W-1:0] rem;
    logic [QW-1:0]    q;

    assign est = EST_W'(last) * EST_W'(RECIP);

    always_ff @(posedge aclk) begin
        x1_reg <= last;
        q1_reg <= QW'(est >> 32);
        x2_reg <= x1_reg;
        q2_reg <= q1_reg;
        p2_reg <= VAL_W'(VAL_W'(q1_reg) * SLOT_DIV);
    end

    // estimate is low by at most one
    always_comb begin
        rem = x2_reg - p2_reg;
        q   = q2_reg + QW'(rem >= SLOT_DIV);
        if (q >= QW'(TABLE_DEPTH)) begin
            slot = SLOT_W'(TABLE_DEPTH - 1);
        end else begin
            slot = q[SLOT_W-1:0];
        end
    end

endmodule

### hw/rtl/clsr_table.sv
module clsr_table
    import clsr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  table_wr_t         wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [VAL_W-1:0]  rd_data
);

    logic [VAL_W-1:0]       mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [VAL_W-1:0]       rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // entries never written read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### hw/rtl/combined_lcg_shuffle_rng.sv
// Combined two-generator LCG with a shuffle table, one 31-bit integer deviate
// (1..2147483562) per request item. A plain request (tuser = 0) runs the table
// read-modify-write in ST_STEP, which waits while an earlier result is unread,
// then the three-step slot-index pipeline (reciprocal multiply, back-multiply,
// correct) that prepares the next table address. A reseed request (tuser = 1,
// seed in tdata) first runs TABLE_DEPTH + 8 steps of generator one through the
// two-stage modular multiplier, each in ST_FILL_MUL, ST_FILL_RED, ST_FILL_UPD,
// then the slot-index pipeline and one plain step. The result sits in an
// output register, so a new request can be accepted while it waits. After reset
// the block runs the slot-index states before it is ready; a request before any
// reseed runs on the reset state.
module combined_lcg_shuffle_rng
    import clsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] seed
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] deviate
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_FILL_MUL,
        ST_FILL_RED,
        ST_FILL_UPD,
        ST_SLOT_A,
        ST_SLOT_B,
        ST_SLOT_C
    } state_t;

    state_t            state_reg, state_next;
    logic [VAL_W-1:0]  g1_reg, g1_next;
    logic [VAL_W-1:0]  g2_reg, g2_next;
    logic [VAL_W-1:0]  last_reg, last_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              step_pend_reg, step_pend_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]  m_data_reg, m_data_next;

    logic [VAL_W-1:0]  g1_step;
    logic [VAL_W-1:0]  g2_step;
    logic [SLOT_W-1:0] slot_calc;
    logic [VAL_W-1:0]  rd_data;
    logic [SLOT_W-1:0] rd_addr;
    table_wr_t         tbl_wr;
    logic [VAL_W-1:0]  seed;
    logic [SUM_W-1:0]  diff;
    logic [SUM_W-1:0]  dev;

    clsr_lcg u_lcg (
        .aclk    (aclk),
        .g1      (g1_reg),
        .g2      (g2_reg),
        .g1_step (g1_step),
        .g2_step (g2_step)
    );

    clsr_slot u_slot (
        .aclk (aclk),
        .last (last_reg),
        .slot (slot_calc)
    );

    clsr_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        seed = s_tdata[VAL_W-1:0];
        diff = SUM_W'(rd_data) - SUM_W'(g2_step);
        if (diff[SUM_W-1] || diff == '0) begin
            dev = diff + SUM_W'(TOP_VALUE);
        end else begin
            dev = diff;
        end
    end

    always_comb begin
        state_next     = state_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        last_next      = last_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        step_pend_next = step_pend_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_data_next    = m_data_reg;
        rd_addr        = slot_reg;
        tbl_wr         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        g1_next    = (seed == '0) ? VAL_W'(1) : seed;
                        g2_next    = (seed == '0) ? VAL_W'(1) : seed;
                        cnt_next   = CNT_W'(TABLE_DEPTH + WARMUP - 1);
                        state_next = ST_FILL_MUL;
                    end else begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                if (!m_tvalid_reg || m_tready) begin
                    g1_next        = g1_step;
                    g2_next        = g2_step;
                    tbl_wr.en      = 1'b1;
                    tbl_wr.addr    = slot_reg;
                    tbl_wr.data    = g1_step;
                    last_next      = VAL_W'(dev);
                    m_data_next    = VAL_W'(dev);
                    m_tvalid_next  = 1'b1;
                    step_pend_next = 1'b0;
                    state_next     = ST_SLOT_A;
                end
            end
            ST_FILL_MUL: begin
                state_next = ST_FILL_RED;
            end
            ST_FILL_RED: begin
                state_next = ST_FILL_UPD;
            end
            ST_FILL_UPD: begin
                g1_next = g1_step;
                if (cnt_reg < CNT_W'(TABLE_DEPTH)) begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = cnt_reg[SLOT_W-1:0];
                    tbl_wr.data = g1_step;
                end
                if (cnt_reg == '0) begin
                    last_next      = g1_step;
                    step_pend_next = 1'b1;
                    state_next     = ST_SLOT_A;
                end else begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_FILL_MUL;
                end
            end
            ST_SLOT_A: begin
                state_next = ST_SLOT_B;
            end
            ST_SLOT_B: begin
                state_next = ST_SLOT_C;
            end
            ST_SLOT_C: begin
                slot_next  = slot_calc;
                rd_addr    = slot_calc;
                state_next = step_pend_reg ? ST_STEP : ST_IDLE;
            end
            default: begin
                state_next = ST_SLOT_A;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SLOT_A;
            g1_reg        <= '0;
            g2_reg        <= G2_RESET;
            last_reg      <= '0;
            slot_reg      <= '0;
            step_pend_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            g1_reg        <= g1_next;
            g2_reg        <= g2_next;
            last_reg      <= last_next;
            slot_reg      <= slot_next;
            step_pend_reg <= step_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

endmodule

### dv/clsr_checker.sv
module clsr_checker
    import clsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] seed
    input  logic        s_tuser,   // [0] opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [30:0] deviate
    output int          failures,
    output int          pending
);

    localparam longint unsigned MOD_G1    = 64'd2147483563;
    localparam longint unsigned MOD_G2    = 64'd2147483399;
    localparam longint unsigned MUL_G1    = 64'd40014;
    localparam longint unsigned MUL_G2    = 64'd40692;
    localparam longint          TOP_DEV   = 64'd2147483562;
    localparam longint unsigned SLOT_SPAN = 64'd1 + (MOD_G1 - 64'd1) / TABLE_DEPTH;
    localparam int              RUN_IN    = 8;

    logic [VAL_W-1:0] gen_one;
    logic [VAL_W-1:0] gen_two;
    logic [VAL_W-1:0] last_dev;
    logic [VAL_W-1:0] shuffle [TABLE_DEPTH];
    logic [VAL_W-1:0] deviates_due [$];
    int               fail_count;

    initial begin
        failures = 0;
        pending  = 0;
    end

    function automatic logic [VAL_W-1:0] mul_mod(input logic [VAL_W-1:0] x,
                                                 input longint unsigned a,
                                                 input longint unsigned m);
        longint unsigned p;
        p = x;
        p = (p * a) % m;
        return p[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] draw_deviate(input logic reseed,
                                                      input logic [VAL_W-1:0] seed);
        logic [VAL_W-1:0] s;
        longint unsigned  slot;
        longint           diff;
        if (reseed) begin
            s = (seed == '0) ? VAL_W'(1) : seed;
            gen_one = s;
            gen_two = s;
            for (int j = TABLE_DEPTH + RUN_IN - 1; j >= 0; j--) begin
                gen_one = mul_mod(gen_one, MUL_G1, MOD_G1);
                if (j < TABLE_DEPTH)
                    shuffle[j] = gen_one;
            end
            last_dev = shuffle[0];
        end
        gen_one = mul_mod(gen_one, MUL_G1, MOD_G1);
        gen_two = mul_mod(gen_two, MUL_G2, MOD_G2);
        slot = last_dev / SLOT_SPAN;
        if (slot >= TABLE_DEPTH)
            slot = TABLE_DEPTH - 1;
        diff = longint'(shuffle[slot]) - longint'(gen_two);
        shuffle[slot] = gen_one;
        if (diff < 1)
            diff = diff + TOP_DEV;
        last_dev = diff[VAL_W-1:0];
        return last_dev;
    endfunction

    always @(posedge aclk) begin
        logic [VAL_W-1:0] want;
        if (!aresetn) begin
            gen_one  = '0;
            gen_two  = G2_RESET;
            last_dev = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                shuffle[i] = '0;
            deviates_due.delete();
            fail_count = 0;
        end else begin
            // results leave before a same-edge request can produce one
            if (m_tvalid && m_tready) begin
                if (deviates_due.size() == 0) begin
                    fail_count++;
                    $error("deviate: expected none, actual %0d", m_tdata[VAL_W-1:0]);
                end else begin
                    want = deviates_due.pop_front();
                    if (m_tdata[VAL_W-1:0] !== want) begin
                        fail_count++;
                        $error("deviate: expected %0d, actual %0d",
                               want, m_tdata[VAL_W-1:0]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                deviates_due.push_back(draw_deviate(s_tuser, s_tdata[VAL_W-1:0]));
        end
        failures <= fail_count;
        pending  <= deviates_due.size();
    end

endmodule

### dv/testbench.sv
module testbench;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 340;
    localparam int SETTLE       = 140;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [30:0] seed
    logic        s_tuser  = 1'b0; // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [30:0] deviate

    int failures;
    int pending;
    int send_idle = 0;
    int rcv_stall = 0;
    int cycles    = 0;

    localparam logic OP_NEXT   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    logic [30:0] odd_seeds [7] = '{31'd0, 31'd1, 31'd2147483398, 31'd2147483399,
                                   31'd2147483562, 31'd2147483563, 31'h7fffffff};

    combined_lcg_shuffle_rng dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    clsr_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .failures (failures),
        .pending  (pending)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_stall);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [30:0] seed);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, seed};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    function automatic logic [30:0] pick_seed;
        if ($urandom_range(9) < 2)
            return odd_seeds[$urandom_range(6)];
        return 31'($urandom);
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // before any reseed the block runs on its reset state
        repeat (3) send_item(OP_NEXT, 31'($urandom));
        send_item(OP_RESEED, 31'd0);
        repeat (2) send_item(OP_NEXT, 31'h7fffffff);
        send_item(OP_RESEED, 31'd1);
        send_item(OP_NEXT, 31'd0);
        send_item(OP_RESEED, 31'h7fffffff);
        send_item(OP_NEXT, 31'($urandom));
        // generator one stuck at zero
        send_item(OP_RESEED, 31'd2147483563);
        repeat (3) send_item(OP_NEXT, 31'($urandom));
        // generator two stuck at zero
        send_item(OP_RESEED, 31'd2147483399);
        repeat (3) send_item(OP_NEXT, 31'($urandom));
        send_item(OP_RESEED, 31'd2147483398);
        send_item(OP_NEXT, 31'($urandom));
        send_item(OP_RESEED, 31'd2147483562);
        send_item(OP_NEXT, 31'($urandom));
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0;  rcv_stall = 0;  end
                1: begin send_idle = 45; rcv_stall = 0;  end
                2: begin send_idle = 0;  rcv_stall = 45; end
                3: begin send_idle = 31; rcv_stall = 31; end
                default: begin send_idle = 0; rcv_stall = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 6)
                    send_item(OP_RESEED, pick_seed());
                else
                    send_item(OP_NEXT, 31'($urandom));
            end
            drain();
        end

        repeat (SETTLE) @(posedge aclk);
        if (failures == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
